// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

// ----- sv/sha256_pkg.sv -----
// Package for the SHA-256 byte stream hasher: payload types, constants, functions.
// No dependencies.
`timescale 1ns / 1ps
package sha256_pkg;
  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        digest_done;
  } out_item_t;

  // Command from the front end to the compression engine.
  typedef struct packed {
    logic [511:0] block;
    logic         last;
  } blk_cmd_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [63:0] BLOCK_BITS = 64'd512;
  localparam int QDEPTH = 2;

  localparam logic [255:0] INIT_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction
endpackage

// ----- sv/sha256_front.sv -----
// Front end: collects bytes into 64-byte blocks and builds the padding blocks.
// Depends on sha256_pkg.
`timescale 1ns / 1ps
module sha256_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  sha256_pkg::in_item_t  in_item,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output sha256_pkg::blk_cmd_t  cmd
);
  import sha256_pkg::*;

  localparam logic [1:0] ST_FILL = 2'd0;
  localparam logic [1:0] ST_PAD1 = 2'd1;
  localparam logic [1:0] ST_PAD2 = 2'd2;

  logic [1:0]   state_r, state_nxt;
  logic [511:0] buf_r, buf_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  total_r, total_nxt;
  logic         full_blk;
  logic [511:0] padded;
  logic [63:0]  len;

  assign in_full = (state_r != ST_FILL) || !cmd_ready;
  assign len = total_r + {55'd0, fill_r, 3'd0};

  always_comb begin
    padded = buf_r;
    for (int i = 0; i < 64; i++) begin
      if (i == fill_r) padded[511-8*i -: 8] = PAD_BYTE;
      else if (i > fill_r) padded[511-8*i -: 8] = 8'd0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    buf_nxt = buf_r;
    fill_nxt = fill_r;
    total_nxt = total_r;
    cmd_valid = 1'b0;
    cmd = '0;
    full_blk = 1'b0;
    unique case (state_r)
      ST_FILL: begin
        if (in_push && !in_full) begin
          if (in_item.byte_present) begin
            buf_nxt[511-8*fill_r -: 8] = in_item.message_byte;
            fill_nxt = fill_r + 6'd1;
            if (fill_r == 6'd63) begin
              full_blk = 1'b1;
              cmd_valid = 1'b1;
              cmd.block = buf_nxt;
              cmd.last = 1'b0;
              total_nxt = total_r + BLOCK_BITS;
            end
          end
          if (in_item.message_end) state_nxt = ST_PAD1;
        end
      end
      ST_PAD1: begin
        if (cmd_ready) begin
          cmd_valid = 1'b1;
          if (fill_r > 6'd55) begin
            cmd.block = padded;
            cmd.last = 1'b0;
            state_nxt = ST_PAD2;
          end else begin
            cmd.block = {padded[511:64], len};
            cmd.last = 1'b1;
            state_nxt = ST_FILL;
            fill_nxt = '0;
            total_nxt = '0;
          end
        end
      end
      ST_PAD2: begin
        if (cmd_ready) begin
          cmd_valid = 1'b1;
          cmd.block = {448'd0, len};
          cmd.last = 1'b1;
          state_nxt = ST_FILL;
          fill_nxt = '0;
          total_nxt = '0;
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      fill_r <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      total_r <= total_nxt;
    end
    buf_r <= buf_nxt;
  end
endmodule

// ----- sv/sha256_queue.sv -----
// Short queue of block commands between the front end and the engine.
// Depends on sha256_pkg.
`timescale 1ns / 1ps
module sha256_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  sha256_pkg::blk_cmd_t wr_data,
  output logic                 wr_ready,
  output logic                 rd_valid,
  input  logic                 rd_en,
  output sha256_pkg::blk_cmd_t rd_data
);
  import sha256_pkg::*;

  blk_cmd_t   mem_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'(QDEPTH));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
  end
endmodule

// ----- sv/sha256_engine.sv -----
// Compression engine: one SHA-256 round per cycle, then digest word output.
// Depends on sha256_pkg.
`timescale 1ns / 1ps
module sha256_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_take,
  input  sha256_pkg::blk_cmd_t  cmd,
  output logic                  out_empty,
  input  logic                  out_pop,
  output sha256_pkg::out_item_t out_item
);
  import sha256_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]   state_r;
  logic [5:0]   t_r;
  logic [2:0]   wn_r;
  logic         last_r;
  logic [255:0] h_r;
  logic [31:0]  w_r [16];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r, f_r, g_r, hh_r;
  logic [31:0]  s0, s1, wnew, t1, t2;

  assign cmd_take = (state_r == ST_IDLE) && cmd_valid;
  assign out_empty = (state_r != ST_OUT);
  assign out_item.digest_word = h_r[255:224];
  assign out_item.word_number = wn_r;
  assign out_item.digest_done = (wn_r == 3'd7);

  assign s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wnew = w_r[0] + s0 + w_r[9] + s1;
  assign t1 = hh_r + (rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25)) +
              ((e_r & f_r) ^ (~e_r & g_r)) + round_k(t_r) + w_r[0];
  assign t2 = (rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22)) +
              ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      h_r <= INIT_HASH;
      t_r <= '0;
      wn_r <= '0;
      last_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            for (int i = 0; i < 16; i++) w_r[i] <= cmd.block[511-32*i -: 32];
            {a_r, b_r, c_r, d_r, e_r, f_r, g_r, hh_r} <= h_r;
            last_r <= cmd.last;
            t_r <= '0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wnew;
          hh_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
          d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
          t_r <= t_r + 6'd1;
          if (t_r == 6'd63) state_r <= ST_ADD;
        end
        ST_ADD: begin
          h_r <= {h_r[255:224] + a_r, h_r[223:192] + b_r, h_r[191:160] + c_r,
                  h_r[159:128] + d_r, h_r[127:96] + e_r, h_r[95:64] + f_r,
                  h_r[63:32] + g_r, h_r[31:0] + hh_r};
          wn_r <= '0;
          state_r <= last_r ? ST_OUT : ST_IDLE;
        end
        ST_OUT: begin
          if (out_pop) begin
            wn_r <= wn_r + 3'd1;
            if (wn_r == 3'd7) begin
              h_r <= INIT_HASH;
              state_r <= ST_IDLE;
            end else begin
              h_r <= {h_r[223:0], 32'd0};
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// ----- sv/sha256_byte_stream_hasher.sv -----
// Top level of the SHA-256 byte stream hasher.
// Depends on sha256_pkg, sha256_front, sha256_queue and sha256_engine.
`timescale 1ns / 1ps
// One byte transfer per cycle is taken while a block is collected and the queue has room;
// each full block passes through the compression engine (load, 64 rounds at one per cycle,
// chain add), and a two-entry block queue lets the next block fill meanwhile, so steady
// input runs at about one byte per cycle. A message end adds one or two padding blocks and
// then the eight digest words, which leave one per pop; input is held off from the end mark
// until the padding blocks are queued.
module sha256_byte_stream_hasher (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  sha256_pkg::in_item_t  in_item,
  output logic                  out_empty,
  input  logic                  out_pop,
  output sha256_pkg::out_item_t out_item
);
  import sha256_pkg::*;

  logic     f_valid, q_ready, q_valid, e_take;
  blk_cmd_t f_cmd, q_cmd;

  sha256_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_item,
    .cmd_valid(f_valid), .cmd_ready(q_ready), .cmd(f_cmd));

  sha256_queue u_queue (
    .clk, .rst_n, .wr_en(f_valid), .wr_data(f_cmd), .wr_ready(q_ready),
    .rd_valid(q_valid), .rd_en(e_take), .rd_data(q_cmd));

  sha256_engine u_engine (
    .clk, .rst_n, .cmd_valid(q_valid), .cmd_take(e_take), .cmd(q_cmd),
    .out_empty, .out_pop, .out_item);
endmodule

// ----- sv/sha256_checker.sv -----
// Port-level checker for the SHA-256 byte stream hasher, with its bind.
// Depends on sha256_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha256_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_empty,
  input logic                  out_pop,
  input sha256_pkg::out_item_t out_item
);
  import sha256_pkg::*;

  `CHK_IMPL(a_done_last, clk, rst_n, !out_empty, out_item.digest_done == (out_item.word_number == 3'd7))
  `CHK_NEXT(a_word_step, clk, rst_n, !out_empty && out_pop && !out_item.digest_done, !out_empty && out_item.word_number == $past(out_item.word_number) + 3'd1)
  `CHK_NEXT(a_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_item))
endmodule

bind sha256_byte_stream_hasher sha256_checker u_checker (
  .clk, .rst_n, .out_empty, .out_pop, .out_item);
